>>> design/pts_pkg.sv
package pts_pkg;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT_ADDR,
        S_ADDR,
        S_WAIT,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_WB,
        S_EMIT_ADDR,
        S_EMIT_WAIT,
        S_EMIT_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_FWD,
        PH_LAST,
        PH_BACK
    } phase_t;

endpackage

>>> design/pts_div.sv
module pts_div
    import pts_pkg::*;
#(
    parameter int NW = 42,
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   rem_s;
    logic          ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_s     = {rem_reg, quo_reg[NW-1]};
        ge        = (rem_s >= {1'b0, dvs_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(rem_s - {1'b0, dvs_reg}) : DW'(rem_s);
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/poisson_tridiagonal_solver.sv
// loads n items at one per cycle, the last one (or the store filling) starts the solve
// solve: n-1 forward steps, one end step and n-1 back steps, each running the shared
// bit-serial divider on a PW-bit dividend (PW = 35 + clog2(MAX_POINTS+1)), then n items out,
// each held while solution_stall is high; new items are taken only after the last is out
// async active-low reset returns to load with an empty store count; store contents undefined
module poisson_tridiagonal_solver
    import pts_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rhs_valid,
    output logic        rhs_stall,
    input  logic [31:0] rhs_value,
    input  logic        rhs_last,
    output logic        solution_valid,
    input  logic        solution_stall,
    output logic [31:0] solution_value,
    output logic        solution_last
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PW    = 34 + CNT_W + 1;
    localparam int DVW   = CNT_W + 1;

    logic [31:0] mem [MAX_POINTS];

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [31:0]        rd_reg;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] cur_reg, cur_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic               ov_reg, ov_next;
    logic [31:0]        oval_reg, oval_next;
    logic               olast_reg, olast_next;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [31:0]        wdata;
    logic               accept;
    logic [CNT_W-1:0]   k;
    logic signed [33:0] a_mul;
    logic [PW-1:0]      prod_mag;
    logic               div_start;
    logic               div_done;
    logic [PW-1:0]      div_quo;
    logic signed [PW-1:0] q_s;
    logic signed [PW-1:0] sum;
    logic signed [31:0] sat;
    logic               out_free;

    localparam logic signed [PW-1:0] SAT_MAX = {{(PW-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [PW-1:0] SAT_MIN = {{(PW-32){1'b1}}, 32'h8000_0000};

    pts_div #(
        .NW(PW),
        .DW(DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (DVW'(k) + DVW'(1)),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign accept    = rhs_valid && (state_reg == S_LOAD);
    assign rhs_stall = (state_reg != S_LOAD);
    assign out_free  = !ov_reg || !solution_stall;
    assign k         = (phase_reg == PH_LAST) ? n_reg : i_reg;
    assign prod_mag  = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign div_start = (state_reg == S_DSTART);
    assign q_s       = prod_reg[PW-1] ? -$signed(div_quo) : $signed(div_quo);
    assign sum       = (phase_reg == PH_FWD) ? q_s + PW'(cur_reg) : q_s;

    always_comb
    begin
        if (sum > SAT_MAX)
        begin
            sat = 32'sh7FFF_FFFF;
        end
        else if (sum < SAT_MIN)
        begin
            sat = 32'sh8000_0000;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    always_comb
    begin
        if (phase_reg == PH_BACK)
        begin
            a_mul = 34'($signed(rd_reg)) + 34'(prev_reg);
        end
        else
        begin
            a_mul = 34'(prev_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept && (rhs_last || cnt_reg == CNT_W'(MAX_POINTS - 1)))
                begin
                    state_next = S_INIT_ADDR;
                end
            end
            S_INIT_ADDR: state_next = S_WAIT;
            S_ADDR:      state_next = S_WAIT;
            S_WAIT:      state_next = S_MUL;
            S_MUL:       state_next = (phase_reg == PH_INIT) ? S_ADDR : S_DSTART;
            S_DSTART:    state_next = S_DIV;
            S_DIV:       state_next = div_done ? S_WB : S_DIV;
            S_WB:
            begin
                if ((phase_reg == PH_LAST && n_reg == CNT_W'(1))
                    || (phase_reg == PH_BACK && i_reg == CNT_W'(1)))
                begin
                    state_next = S_EMIT_ADDR;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_EMIT_ADDR: state_next = S_EMIT_WAIT;
            S_EMIT_WAIT: state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = (i_reg == n_reg - 1'b1) ? S_LOAD : S_EMIT_ADDR;
                end
            end
            default:     state_next = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        addr_next  = addr_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        prod_next  = prod_reg;
        ov_next    = ov_reg && solution_stall;
        oval_next  = oval_reg;
        olast_next = olast_reg;
        we         = 1'b0;
        waddr      = cnt_reg[IDX_W-1:0];
        wdata      = rhs_value;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    n_next   = cnt_reg + 1'b1;
                end
            end
            S_INIT_ADDR:
            begin
                addr_next  = '0;
                phase_next = PH_INIT;
            end
            S_ADDR:
            begin
                if (phase_reg == PH_BACK)
                begin
                    addr_next = IDX_W'(i_reg - 1'b1);
                end
                else
                begin
                    addr_next = i_reg[IDX_W-1:0];
                end
            end
            S_MUL:
            begin
                if (phase_reg == PH_INIT)
                begin
                    prev_next = $signed(rd_reg);
                    if (n_reg == CNT_W'(1))
                    begin
                        phase_next = PH_LAST;
                    end
                    else
                    begin
                        phase_next = PH_FWD;
                        i_next     = CNT_W'(1);
                    end
                end
                else
                begin
                    cur_next  = $signed(rd_reg);
                    prod_next = PW'(a_mul * $signed({1'b0, k}));
                end
            end
            S_WB:
            begin
                we        = 1'b1;
                wdata     = sat;
                prev_next = sat;
                case (phase_reg)
                    PH_FWD:
                    begin
                        waddr = i_reg[IDX_W-1:0];
                        if (i_reg == n_reg - 1'b1)
                        begin
                            phase_next = PH_LAST;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    PH_LAST:
                    begin
                        waddr      = IDX_W'(n_reg - 1'b1);
                        phase_next = PH_BACK;
                        i_next     = n_reg - 1'b1;
                        if (n_reg == CNT_W'(1))
                        begin
                            i_next = '0;
                        end
                    end
                    PH_BACK:
                    begin
                        waddr  = IDX_W'(i_reg - 1'b1);
                        i_next = i_reg - 1'b1;
                    end
                    default:
                    begin
                        we = 1'b0;
                    end
                endcase
            end
            S_EMIT_ADDR:
            begin
                addr_next = i_reg[IDX_W-1:0];
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oval_next  = rd_reg;
                    olast_next = (i_reg == n_reg - 1'b1);
                    if (i_reg == n_reg - 1'b1)
                    begin
                        cnt_next = '0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            phase_reg <= PH_INIT;
            cnt_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        prod_reg  <= prod_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[addr_reg];
    end

    assign solution_valid = ov_reg;
    assign solution_value = oval_reg;
    assign solution_last  = olast_reg;

    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(solution_valid) |-> $past(state_reg == S_EMIT_OUT))
        else $error("result item raised outside emit");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside wait state");

endmodule
